### rtl/fsal_pkg.sv
// Shared types, constants and helpers for the frame assembler.
`timescale 1ns / 1ps

package fsal_pkg;

   // Largest payload length that a length byte may announce.
   localparam int MAX_PAYLOAD_BYTES = 32;

   // Frame counters must reach header (3) + payload + two CRC bytes.
   localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 6);

   localparam int BYTE_W    = 8;
   localparam int OP_W      = 2;
   localparam int POS_W     = 6;
   localparam int CRC_W     = 2;
   localparam int TIMEOUT_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   // Item kinds carried on the request channel.
   localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd2;

   // Register reset values.
   localparam logic [BYTE_W-1:0]    START_BYTE_RESET   = 8'hAA;
   localparam logic [CRC_W-1:0]     CRC_LENGTH_RESET   = 2'd2;
   localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RESET = 16'd200;

   // Receiver phases.
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   // Start byte, length byte and command byte.
   localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(3);

   typedef struct packed {
      logic [BYTE_W-1:0]    start_byte;
      logic [CRC_W-1:0]     crc_length;
      logic [TIMEOUT_W-1:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           rx_phase;
      logic [CNT_W-1:0]     byte_count;
      logic [CNT_W-1:0]     expected_total;
      logic                 frame_pending;
      logic [CNT_W-1:0]     held_frame_len;
      logic [TIMEOUT_W-1:0] idle_ticks;
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic              stored;
      logic [BYTE_W-1:0] stored_byte;
      logic [POS_W-1:0]  byte_position;
      logic              frame_done;
      logic [POS_W-1:0]  frame_length;
      logic              length_rejected;
      logic              timed_out;
      logic              busy_res;
      logic              pending;
   } result_type;

   localparam state_type STATE_RESET = '{
      rx_phase:       PH_HUNT,
      byte_count:     '0,
      expected_total: '0,
      frame_pending:  1'b0,
      held_frame_len: '0,
      idle_ticks:     '0
   };

   // Positions and lengths leave the block on a fixed 6-bit field.
   function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
      return POS_W'(v);
   endfunction

   // A CRC length of 0 behaves as 1, and 3 behaves as 2.
   function automatic logic [CRC_W-1:0] clamp_crc(input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] r;
      r = v;
      if (v == 2'd0) r = 2'd1;
      if (v == 2'd3) r = 2'd2;
      return r;
   endfunction

endpackage

### rtl/sof_length_frame_assembler_unit.sv
// Top level of the start-byte and length-prefixed frame assembler.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: rx_byte; tuser: op
// rsp_      out        rsp_tvalid/rsp_tready  tdata: status; tuser: stored; tlast: done
// csr_      in         csr_we                 csr_index, csr_wdata
//
// Every request transaction produces exactly one response transaction. The block
// takes one transaction per clock cycle while the response side is not stalled;
// each passes through the request register and then the response register, where
// the frame state is updated by a single pass of compare and counter logic.
// The synchronous reset empties both registers and returns the receiver to hunting.
// A stalled response holds its register; the request register still takes one
// more transaction, and backpressure reaches req_tready only when both are full.

module sof_length_frame_assembler_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] rx_byte
   input  logic [1:0]                     req_tuser,  // [1:0] op
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [7:0] stored_byte,
                                                      // [13:8] byte_position,
                                                      // [19:14] frame_length,
                                                      // [20] length_rejected,
                                                      // [21] timed_out,
                                                      // [22] busy_res, [23] pending
   output logic                           rsp_tuser,  // [0] stored
   output logic                           rsp_tlast,  // frame_done
   // Configuration port.
   input  logic                           csr_we,
   input  logic [fsal_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fsal_pkg::CSR_W-1:0]     csr_wdata
);
   import fsal_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   result_type result_in;
   result_type result_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;
   logic       advance;

   fsal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsal_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // The held request moves on whenever the response register is free or emptying.
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (advance)    item_valid_in = 1'b0;
      if (req_accept) item_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.op      <= req_tuser;
         item_ff.rx_byte <= req_tdata;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.stored;
   assign rsp_tlast  = result_ff.frame_done;
   assign rsp_tdata  = {result_ff.pending,
                        result_ff.busy_res,
                        result_ff.timed_out,
                        result_ff.length_rejected,
                        result_ff.frame_length,
                        result_ff.byte_position,
                        result_ff.stored_byte};

endmodule

### rtl/fsal_csr.sv
// Configuration registers of the frame assembler.
`timescale 1ns / 1ps

module fsal_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fsal_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fsal_pkg::CSR_W-1:0]     csr_wdata,
   output fsal_pkg::cfg_type              cfg
);
   import fsal_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:   cfg_in.start_byte   = csr_wdata[BYTE_W-1:0];
            CSR_CRC_LENGTH:   cfg_in.crc_length   = csr_wdata[CRC_W-1:0];
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout = csr_wdata[TIMEOUT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= START_BYTE_RESET;
         cfg_ff.crc_length   <= CRC_LENGTH_RESET;
         cfg_ff.idle_timeout <= IDLE_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/fsal_step.sv
// Next-state and result logic for one request item.
`timescale 1ns / 1ps

module fsal_step (
   input  fsal_pkg::cfg_type    cfg,
   input  fsal_pkg::state_type  state,
   input  fsal_pkg::item_type   item,
   output fsal_pkg::state_type  state_next,
   output fsal_pkg::result_type result
);
   import fsal_pkg::*;

   logic [CNT_W-1:0]     count_inc;
   logic [TIMEOUT_W-1:0] ticks_inc;
   logic [CRC_W-1:0]     crc_eff;

   assign count_inc = state.byte_count + CNT_W'(1);
   assign ticks_inc = (state.idle_ticks == '1) ? state.idle_ticks
                                               : state.idle_ticks + TIMEOUT_W'(1);
   assign crc_eff   = clamp_crc(cfg.crc_length);

   always_comb begin
      state_next = state;
      result     = '0;

      case (item.op)
         OP_BYTE: begin
            state_next.idle_ticks = '0;
            if (!state.frame_pending) begin
               case (state.rx_phase)
                  PH_HUNT: begin
                     if (item.rx_byte == cfg.start_byte) begin
                        result.stored         = 1'b1;
                        result.stored_byte    = item.rx_byte;
                        state_next.byte_count = CNT_W'(1);
                        state_next.rx_phase   = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (item.rx_byte > BYTE_W'(MAX_PAYLOAD_BYTES)) begin
                        result.length_rejected = 1'b1;
                        state_next.rx_phase    = PH_HUNT;
                        state_next.byte_count  = '0;
                     end else begin
                        result.stored             = 1'b1;
                        result.stored_byte        = item.rx_byte;
                        result.byte_position      = POS_W'(1);
                        state_next.expected_total = HEADER_BYTES
                                                  + CNT_W'(item.rx_byte)
                                                  + CNT_W'(crc_eff);
                        state_next.byte_count     = CNT_W'(2);
                        state_next.rx_phase       = PH_BODY;
                     end
                  end
                  default: begin
                     result.stored         = 1'b1;
                     result.stored_byte    = item.rx_byte;
                     result.byte_position  = to_pos(state.byte_count);
                     state_next.byte_count = count_inc;
                     if (count_inc >= state.expected_total) begin
                        result.frame_done         = 1'b1;
                        state_next.held_frame_len = count_inc;
                        state_next.frame_pending  = 1'b1;
                        state_next.rx_phase       = PH_HUNT;
                        state_next.byte_count     = '0;
                     end
                  end
               endcase
            end
         end
         OP_TICK: begin
            state_next.idle_ticks = ticks_inc;
            if (state.rx_phase != PH_HUNT && ticks_inc > cfg.idle_timeout) begin
               result.timed_out      = 1'b1;
               state_next.rx_phase   = PH_HUNT;
               state_next.byte_count = '0;
            end
         end
         OP_RELEASE: begin
            state_next.frame_pending  = 1'b0;
            state_next.held_frame_len = '0;
            state_next.expected_total = '0;
            state_next.rx_phase       = PH_HUNT;
            state_next.byte_count     = '0;
         end
         default: begin
            state_next = state;
         end
      endcase

      // Status reflects the state after this item.
      result.frame_length = state_next.frame_pending ? to_pos(state_next.held_frame_len)
                                                     : '0;
      result.busy_res     = (state_next.rx_phase != PH_HUNT);
      result.pending      = state_next.frame_pending;
   end

endmodule

### rtl/fsal_checker.sv
// Port-level checks for the frame assembler, bound to its top level.
`timescale 1ns / 1ps

module fsal_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A discarded or rejected byte reports neither a value nor a position.
   a_unstored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[13:0] == 14'd0)
      else $error("unstored transaction carries a byte or position");

   // A completing byte is stored, leaves a frame pending and the receiver hunting.
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser && rsp_tdata[23] && !rsp_tdata[22]
                                  && rsp_tdata[19:14] != 6'd0)
      else $error("frame completion without a pending frame");

   // The frame length is reported only while a frame is pending.
   a_len_when_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[23] |-> rsp_tdata[19:14] == 6'd0)
      else $error("frame length reported with nothing pending");

   // A timeout always leaves the receiver outside a frame.
   a_timeout_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> !rsp_tdata[22] && !rsp_tuser)
      else $error("timeout left the receiver inside a frame");

   // A stalled response holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind sof_length_frame_assembler_unit fsal_checker u_fsal_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### verif/sof_length_frame_assembler_unit_tb.sv
// Self-checking testbench for the start-byte and length-prefixed frame assembler.
`timescale 1ns / 1ps

module sof_length_frame_assembler_unit_tb;
   import fsal_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 8;
   // Cycles without any transaction on either channel before the run is declared hung.
   // The longest legitimate quiet stretch is the receiver hold-off below.
   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 120;
   // Two pipeline registers sit between request and response; a few extra
   // cycles let any stray response show up before a register write or the end.
   localparam int SETTLE_CYCLES   = 4;
   // Random items per configuration setting that actually move the receiver.
   localparam int PHASE_ITEMS     = 200;
   // The request kind that the block does not define.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Tracks the receiver state, predicts one response per request transaction
   // and compares every response against the oldest prediction.
   class frame_scoreboard;
      logic [BYTE_W-1:0]    start_val;
      logic [CRC_W-1:0]     crc_sel;
      logic [TIMEOUT_W-1:0] timeout_lim;
      logic [1:0]           phase;
      logic [CNT_W-1:0]     count;
      logic [CNT_W-1:0]     total;
      logic                 held;
      logic [CNT_W-1:0]     held_len;
      logic [TIMEOUT_W-1:0] ticks;
      result_type           expected_q[$];
      int                   errors;
      int                   active_items;
      int                   responses;

      function new();
         start_val    = START_BYTE_RESET;
         crc_sel      = CRC_LENGTH_RESET;
         timeout_lim  = IDLE_TIMEOUT_RESET;
         phase        = PH_HUNT;
         count        = '0;
         total        = '0;
         held         = 1'b0;
         held_len     = '0;
         ticks        = '0;
         errors       = 0;
         active_items = 0;
         responses    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_START_BYTE:   start_val = v[BYTE_W-1:0];
            CSR_CRC_LENGTH:   crc_sel = v[CRC_W-1:0];
            CSR_IDLE_TIMEOUT: timeout_lim = v[TIMEOUT_W-1:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // Advances the receiver by one accepted request and queues its response.
      function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
         result_type       r;
         logic [CNT_W-1:0] crc_bytes;
         r = '0;
         case (op)
            OP_BYTE: begin
               ticks = '0;
               if (!held) begin
                  if (phase == PH_HUNT) begin
                     if (b == start_val) begin
                        r.stored      = 1'b1;
                        r.stored_byte = b;
                        count         = CNT_W'(1);
                        phase         = PH_LEN;
                     end
                  end else if (phase == PH_LEN) begin
                     if (b > MAX_PAYLOAD_BYTES) begin
                        r.length_rejected = 1'b1;
                        phase             = PH_HUNT;
                        count             = '0;
                     end else begin
                        // Out-of-range CRC sizes fold onto the nearest legal one.
                        crc_bytes = CNT_W'(crc_sel);
                        if (crc_sel == 2'd0) crc_bytes = CNT_W'(1);
                        if (crc_sel == 2'd3) crc_bytes = CNT_W'(2);
                        r.stored        = 1'b1;
                        r.stored_byte   = b;
                        r.byte_position = POS_W'(1);
                        total           = HEADER_BYTES + CNT_W'(b) + crc_bytes;
                        count           = CNT_W'(2);
                        phase           = PH_BODY;
                     end
                  end else begin
                     r.stored        = 1'b1;
                     r.stored_byte   = b;
                     r.byte_position = POS_W'(count);
                     count           = count + 1'b1;
                     if (count >= total) begin
                        r.frame_done = 1'b1;
                        held_len     = count;
                        held         = 1'b1;
                        phase        = PH_HUNT;
                        count        = '0;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (ticks != '1) ticks = ticks + 1'b1;
               if (phase != PH_HUNT && ticks > timeout_lim) begin
                  r.timed_out = 1'b1;
                  phase       = PH_HUNT;
                  count       = '0;
               end
            end
            OP_RELEASE: begin
               held     = 1'b0;
               held_len = '0;
               total    = '0;
               phase    = PH_HUNT;
               count    = '0;
            end
            default: ;
         endcase
         r.frame_length = held ? POS_W'(held_len) : '0;
         r.busy_res     = (phase != PH_HUNT);
         r.pending      = held;
         if (op == OP_TICK || op == OP_RELEASE || r.stored || r.length_rejected)
            active_items++;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                      responses, name, got, want));
      endtask

      task check_response(logic [23:0] data, logic user, logic last);
         result_type want;
         responses++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response %0d (data %h) arrived with none expected",
                                      responses, data));
            return;
         end
         want = expected_q.pop_front();
         compare_field("stored", 8'(user), 8'(want.stored));
         compare_field("stored_byte", data[7:0], want.stored_byte);
         compare_field("byte_position", 8'(data[13:8]), 8'(want.byte_position));
         compare_field("frame_done", 8'(last), 8'(want.frame_done));
         compare_field("frame_length", 8'(data[19:14]), 8'(want.frame_length));
         compare_field("length_rejected", 8'(data[20]), 8'(want.length_rejected));
         compare_field("timed_out", 8'(data[21]), 8'(want.timed_out));
         compare_field("busy_res", 8'(data[22]), 8'(want.busy_res));
         compare_field("pending", 8'(data[23]), 8'(want.pending));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] rx_byte
   logic [1:0]           req_tuser;   // [1:0] op
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;   // [7:0] stored_byte, [13:8] byte_position,
                                      // [19:14] frame_length, [20] length_rejected,
                                      // [21] timed_out, [22] busy_res, [23] pending
   logic                 rsp_tuser;   // [0] stored
   logic                 rsp_tlast;   // frame_done
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   frame_scoreboard sb;
   // When clear, the sender offers items back to back.
   bit gaps_on;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit hold_off_req;
   int quiet_cycles;

   sof_length_frame_assembler_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Both channels are observed at the rising edge, where the values driven
   // at the previous falling edge are stable. A request accepted at this edge
   // cannot have its response at the same edge, so the two checks never race.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Watchdog: a run that stops moving transactions is hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Response side backpressure. Runs of ready and stall alternate, most of
   // them short; now and then a long stall or a long stall-free stretch.
   // On request the receiver holds off for a long stretch so the two internal
   // registers fill up and the block stalls its request side.
   initial begin
      int run;
      int mode;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 99);
            if (mode < 55) begin
               rsp_tready <= 1'b1;
               run = $urandom_range(1, 12);
            end else if (mode < 62) begin
               rsp_tready <= 1'b1;
               run = 150;
            end else if (mode < 95) begin
               rsp_tready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               run = $urandom_range(8, 40);
            end
            repeat (run) @(negedge clock);
         end
      end
   end

   // Offers one request transaction, after a random gap when gaps are on,
   // and returns at the rising edge where it was accepted. Valid stays high
   // afterwards; the next call either replaces the data or lowers valid at
   // the following falling edge, before it could be taken twice.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
      int gap;
      int roll;
      gap  = 0;
      roll = $urandom_range(0, 99);
      if (gaps_on) begin
         if (roll >= 94) gap = $urandom_range(8, 30);
         else if (roll >= 66) gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic tick_burst(input int n);
      repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles; only called while idle.
   task automatic write_cfg(input logic [BYTE_W-1:0] start_v, input logic [CRC_W-1:0] crc_v,
                            input logic [TIMEOUT_W-1:0] timeout_v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_wdata <= CSR_W'(start_v);
      @(negedge clock);
      csr_index <= CSR_CRC_LENGTH;
      csr_wdata <= CSR_W'(crc_v);
      @(negedge clock);
      csr_index <= CSR_IDLE_TIMEOUT;
      csr_wdata <= CSR_W'(timeout_v);
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(CSR_START_BYTE, CSR_W'(start_v));
      sb.set_reg(CSR_CRC_LENGTH, CSR_W'(crc_v));
      sb.set_reg(CSR_IDLE_TIMEOUT, CSR_W'(timeout_v));
   endtask

   // Random traffic until the given number of items has moved the receiver.
   // Most of it is well-formed frames with random content, so the body phase
   // and the pending hold are reached often; the rest is truncated frames,
   // oversize lengths, tick bursts that run past the idle limit, releases at
   // odd moments, stray bytes and plain noise of every request kind.
   task automatic run_random(input int budget);
      int target;
      int roll;
      int len;
      int body;
      int i;
      target = sb.active_items + budget;
      while (sb.active_items < target) begin
         gaps_on = ($urandom_range(0, 99) < 70);
         roll    = $urandom_range(0, 99);
         if (roll < 75) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) len = $urandom_range(0, 6);
            else if (roll < 85) len = $urandom_range(7, MAX_PAYLOAD_BYTES - 1);
            else if (roll < 93) len = MAX_PAYLOAD_BYTES;
            else len = $urandom_range(MAX_PAYLOAD_BYTES + 1, 255);
            send_item(OP_BYTE, sb.start_val);
            send_item(OP_BYTE, 8'(len));
            if (len <= MAX_PAYLOAD_BYTES) begin
               // Command byte, payload and CRC.
               body = 1 + len + ((sb.crc_sel == 2'd0) ? 1 : (sb.crc_sel == 2'd3) ? 2 : 
                                 int'(sb.crc_sel));
               if ($urandom_range(0, 99) < 8) body = $urandom_range(0, body - 1);
               for (i = 0; i < body; i++) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 1 && sb.timeout_lim <= 200) begin
                     tick_burst(int'(sb.timeout_lim) + 1);
                  end else if (roll < 6) begin
                     if (sb.timeout_lim < 10)
                        tick_burst($urandom_range(1, int'(sb.timeout_lim) + 2));
                     else
                        tick_burst($urandom_range(1, 3));
                  end
                  send_item(OP_BYTE, 8'($urandom_range(0, 255)));
               end
               // Bytes and ticks that arrive while the frame waits for release.
               if ($urandom_range(0, 99) < 20)
                  repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 99) < 15) tick_burst($urandom_range(1, 3));
               if ($urandom_range(0, 99) < 90) send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
            end
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else if (roll < 90) begin
            tick_burst($urandom_range(1, 5));
         end else if (roll < 93) begin
            send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
         end else if (roll < 95) begin
            // The sender pauses until the block has answered everything.
            wait_drained();
         end else begin
            repeat ($urandom_range(1, 4)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_BYTE;
      csr_we       = 1'b0;
      csr_index    = CSR_START_BYTE;
      csr_wdata    = '0;
      gaps_on      = 1'b0;
      hold_off_req = 1'b0;
      quiet_cycles = 0;
      sb           = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset configuration: start byte 0xAA, two CRC
      // bytes. Idle-state ticks, the unused kind and a release with nothing
      // pending; non-start bytes at both extremes; a minimal frame that ends
      // pending, a byte and a tick while pending, then its release; lengths
      // just over the limit and at the top of the byte range; and a release
      // that abandons a frame after its length byte.
      send_item(OP_TICK, 8'hFF);
      send_item(OP_UNUSED, 8'h00);
      send_item(OP_RELEASE, 8'hFF);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, START_BYTE_RESET);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'h55);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, START_BYTE_RESET);
      send_item(OP_TICK, 8'h00);
      send_item(OP_RELEASE, 8'h00);
      send_item(OP_BYTE, START_BYTE_RESET);
      send_item(OP_BYTE, 8'(MAX_PAYLOAD_BYTES + 1));
      send_item(OP_BYTE, START_BYTE_RESET);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, START_BYTE_RESET);
      send_item(OP_BYTE, 8'h01);
      send_item(OP_RELEASE, 8'h00);
      wait_drained();

      // Random phases over several settings, the register extremes among them.
      // A zero idle limit aborts a frame on its first tick; CRC sizes 0 and 3
      // must behave as 1 and 2.
      write_cfg(8'h00, 2'd1, 16'd0);
      run_random(PHASE_ITEMS);
      wait_drained();

      write_cfg(8'hFF, 2'd3, 16'd3);
      hold_off_req = 1'b1;
      run_random(PHASE_ITEMS);
      wait_drained();

      write_cfg(8'h5A, 2'd0, 16'hFFFF);
      run_random(PHASE_ITEMS);
      wait_drained();

      write_cfg(START_BYTE_RESET, CRC_LENGTH_RESET, IDLE_TIMEOUT_RESET);
      run_random(PHASE_ITEMS);
      wait_drained();

      write_cfg(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                16'($urandom_range(0, 12)));
      hold_off_req = 1'b1;
      run_random(PHASE_ITEMS);
      wait_drained();

      write_cfg(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                16'($urandom_range(0, 65535)));
      run_random(PHASE_ITEMS);
      wait_drained();

      if (sb.outstanding() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.outstanding()));
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
rtl/fsal_pkg.sv
rtl/fsal_csr.sv
rtl/fsal_step.sv
rtl/sof_length_frame_assembler_unit.sv
rtl/fsal_checker.sv
verif/sof_length_frame_assembler_unit_tb.sv
